### rtl/core/rbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and codes for the reconnect backoff scheduler
// Request and result kinds, register indexes and controller command/status.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_CONN   = 3'd2;
  localparam logic [2:0] REQ_FAIL   = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_DIAL    = 3'd1;
  localparam logic [2:0] KIND_GIVEUP  = 3'd2;
  localparam logic [2:0] KIND_ADDED   = 3'd3;
  localparam logic [2:0] KIND_PRESENT = 3'd4;
  localparam logic [2:0] KIND_FULL    = 3'd5;
  localparam logic [2:0] KIND_REMOVED = 3'd6;
  localparam logic [2:0] KIND_NOTFND  = 3'd7;

  localparam logic [2:0] REG_BASE    = 3'd0;
  localparam logic [2:0] REG_MAXBO   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_MAXATT  = 3'd3;
  localparam logic [2:0] REG_MAXTGT  = 3'd4;
  localparam logic [2:0] REG_PERSIST = 3'd5;

  localparam int CFG_BITS = 24;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic lookup;    // single request: decide and update
    logic scan_clr;  // reset scan index
    logic scan_step; // evaluate one slot, update, may queue a result
    logic bo_step;   // one doubling step of the backoff unit
    logic commit;    // write dial update of scan slot
    logic done_out;  // present the closing done result
  } rbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_last;  // current scan slot is the final one
    logic need_dial;  // current slot needs a dial (backoff run)
    logic bo_busy;    // backoff unit still doubling
  } rbs_sts_t;

endpackage
`default_nettype wire

### rtl/core/rbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_ctrl: sequencing controller
// Steps a request through lookup or a slot-by-slot scan with backoff runs.
// ----------------------------------------------------------------------------
module rbs_ctrl
  import rbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     out_free,  // output register empty or being taken
  input  rbs_sts_t      sts,
  output rbs_cmd_t      cmd,
  output logic          in_ready
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DEC  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_BO   = 6'b001000,
    ST_CMT  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.is_tick) begin
          cmd.scan_clr = 1'b1;
          state_next = ST_SCAN;
        end else if (out_free) begin
          cmd.lookup = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          cmd.scan_step = 1'b1;
          if (sts.need_dial) state_next = ST_BO;
          else if (sts.scan_last) state_next = ST_DONE;
        end
      end
      ST_BO: begin
        cmd.bo_step = 1'b1;
        if (!sts.bo_busy) state_next = ST_CMT;
      end
      ST_CMT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = sts.scan_last ? ST_DONE : ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.done_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_bo_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BO && !sts.bo_busy) |=> state == ST_CMT)
    else $error("backoff did not lead to commit");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.lookup, cmd.scan_step, cmd.commit, cmd.done_out}))
    else $error("conflicting commands");

endmodule
`default_nettype wire

### rtl/core/rbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_dp: target table and scan datapath
// Holds slot state and registers, runs lookups, the scan and the backoff.
// ----------------------------------------------------------------------------
module rbs_dp
  import rbs_pkg::*;
#(
  parameter int SLOTS        = 16,
  parameter int ADDR_BITS    = 48,
  parameter int TIME_BITS    = 40,
  parameter int ATTEMPT_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_idx,
  input  wire logic [CFG_BITS-1:0]    cfg_data,
  input  wire logic [2:0]             req_type,
  input  wire logic [ADDR_BITS-1:0]   address,
  input  wire logic [TIME_BITS-1:0]   now_time,
  input  wire logic [15:0]            live_mask,
  input  rbs_cmd_t                    cmd,
  output rbs_sts_t                    sts,
  input  wire logic                   out_take,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [ADDR_BITS-1:0]        out_addr,
  output logic [3:0]                  out_slot,
  output logic                        out_last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = TIME_BITS + 1;
  localparam logic [ATTEMPT_BITS-1:0] ATT_MAX = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [19:0] base_bo;
  logic [23:0] max_bo, dial_to;
  logic [7:0]  max_att;
  logic [4:0]  max_tgt;
  logic        persist;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_bo <= 20'd1000; max_bo <= 24'd60000; dial_to <= 24'd10000;
      max_att <= 8'd0; max_tgt <= 5'd16; persist <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE:    base_bo <= cfg_data[19:0];
        REG_MAXBO:   max_bo  <= cfg_data[23:0];
        REG_TIMEOUT: dial_to <= cfg_data[23:0];
        REG_MAXATT:  max_att <= cfg_data[7:0];
        REG_MAXTGT:  max_tgt <= cfg_data[4:0];
        REG_PERSIST: persist <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SLOTS-1:0]        vld;
  logic [ADDR_BITS-1:0]    sa   [SLOTS];
  logic [ATTEMPT_BITS-1:0] att  [SLOTS];
  logic [SLOTS-1:0]        infl;
  logic [TIME_BITS-1:0]    ddl  [SLOTS];
  logic [TIME_BITS-1:0]    nat  [SLOTS];
  logic [CW-1:0]           act;

  logic [2:0]           r_req;
  logic [ADDR_BITS-1:0] r_addr;
  logic [TIME_BITS-1:0] r_now;
  logic [15:0]          r_live;
  logic [SW-1:0]        sidx;

  // lookup: match and lowest free slot
  logic            hit, fre;
  logic [SW-1:0]   hit_s, fre_s;
  always_comb begin
    hit = 1'b0; hit_s = '0; fre = 1'b0; fre_s = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (vld[s] && sa[s] == r_addr) begin hit = 1'b1; hit_s = SW'(s); end
      if (!vld[s]) begin fre = 1'b1; fre_s = SW'(s); end
    end
  end
  logic room;
  assign room = fre && (32'(act) < 32'(max_tgt));

  // scan slot evaluation
  logic cur_live, cur_skip, cur_give, cur_dial;
  always_comb begin
    cur_live = (32'(sidx) < 16) && r_live[4'(sidx)];
    cur_skip = (infl[sidx] && r_now < ddl[sidx]) || (nat[sidx] > r_now);
    cur_give = (max_att != 8'd0) && (32'(att[sidx]) >= 32'(max_att));
    cur_dial = vld[sidx] && !cur_live && !cur_skip && !cur_give;
  end

  // backoff unit: doubles one step a cycle
  logic [ATTEMPT_BITS-1:0] new_att, bo_i;
  logic [DW-1:0]           bo_d;
  assign new_att = (att[sidx] < ATT_MAX) ? att[sidx] + 1'b1 : att[sidx];
  logic bo_more;
  assign bo_more = (bo_i < new_att) && (bo_d < DW'(max_bo));

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cur_dial) begin
      bo_d <= DW'(base_bo);
      bo_i <= ATTEMPT_BITS'(1);
    end else if (cmd.bo_step && bo_more) begin
      bo_d <= bo_d << 1;
      bo_i <= bo_i + 1'b1;
    end
  end

  logic [DW-1:0] bo_cap, sum_n, sum_d;
  always_comb begin
    bo_cap = (bo_d < DW'(max_bo)) ? bo_d : DW'(max_bo);
    sum_n  = DW'(r_now) + bo_cap;
    sum_d  = DW'(r_now) + DW'(dial_to);
  end

  assign sts.is_tick   = (r_req == REQ_TICK);
  assign sts.scan_last = (32'(sidx) == SLOTS - 1);
  assign sts.need_dial = cur_dial;
  assign sts.bo_busy   = bo_more;

  logic         o_set;
  logic [2:0]   o_kind;
  logic [ADDR_BITS-1:0] o_addr;
  logic [SW-1:0] o_slot;
  logic         o_last;

  always_comb begin
    o_set = 1'b0; o_kind = KIND_DONE; o_addr = r_addr; o_slot = '0; o_last = 1'b1;
    if (cmd.lookup) begin
      o_set = 1'b1;
      case (r_req)
        REQ_ADD: begin
          if (hit) begin o_kind = KIND_PRESENT; o_slot = hit_s; end
          else if (room) begin o_kind = KIND_ADDED; o_slot = fre_s; end
          else o_kind = KIND_FULL;
        end
        REQ_REMOVE: begin
          if (hit) begin o_kind = KIND_REMOVED; o_slot = hit_s; end
          else o_kind = KIND_NOTFND;
        end
        REQ_CONN: begin
          if (hit) begin o_kind = KIND_DONE; o_slot = hit_s; end
          else if (!persist) o_kind = KIND_NOTFND;
          else if (room) begin o_kind = KIND_ADDED; o_slot = fre_s; end
          else o_kind = KIND_FULL;
        end
        REQ_FAIL: begin
          if (hit) o_slot = hit_s;
          else o_kind = KIND_NOTFND;
        end
        default: ;
      endcase
    end else if (cmd.scan_step && vld[sidx] && !cur_live && !cur_skip && cur_give) begin
      o_set = 1'b1; o_kind = KIND_GIVEUP; o_addr = sa[sidx]; o_slot = sidx; o_last = 1'b0;
    end else if (cmd.commit) begin
      o_set = 1'b1; o_kind = KIND_DIAL; o_addr = sa[sidx]; o_slot = sidx; o_last = 1'b0;
    end else if (cmd.done_out) begin
      o_set = 1'b1; o_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (o_set) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (o_set) begin
      out_kind <= o_kind;
      out_addr <= o_addr;
      out_slot <= 4'(o_slot);
      out_last <= o_last;
    end
  end

  // table updates
  logic do_fill;
  assign do_fill = cmd.lookup && !hit && room &&
                   (r_req == REQ_ADD || (r_req == REQ_CONN && persist));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_req <= req_type; r_addr <= address; r_now <= now_time; r_live <= live_mask;
    end
    if (cmd.scan_clr) sidx <= '0;
    else if ((cmd.scan_step && !cur_dial && !sts.scan_last) ||
             (cmd.commit && !sts.scan_last)) sidx <= sidx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      act <= '0;
    end else begin
      if (do_fill) begin
        vld[fre_s] <= 1'b1;
        act <= act + 1'b1;
      end
      if (cmd.lookup && hit && r_req == REQ_REMOVE) begin
        vld[hit_s] <= 1'b0;
        act <= act - 1'b1;
      end
      if (cmd.scan_step && vld[sidx] && !cur_live && !cur_skip && cur_give) begin
        vld[sidx] <= 1'b0;
        act <= act - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_fill) begin
      sa[fre_s] <= r_addr; ddl[fre_s] <= '0;
      att[fre_s] <= '0; infl[fre_s] <= 1'b0; nat[fre_s] <= r_now;
    end
    if (cmd.lookup && hit && r_req == REQ_CONN) begin
      att[hit_s] <= '0; infl[hit_s] <= 1'b0; nat[hit_s] <= r_now;
    end
    if (cmd.lookup && hit && r_req == REQ_FAIL) infl[hit_s] <= 1'b0;
    if (cmd.scan_step && vld[sidx] && cur_live) begin
      att[sidx] <= '0; infl[sidx] <= 1'b0; nat[sidx] <= r_now;
    end
    if (cmd.commit) begin
      att[sidx]  <= new_att;
      infl[sidx] <= 1'b1;
      ddl[sidx]  <= sum_d[TIME_BITS] ? TIME_MAX : sum_d[TIME_BITS-1:0];
      nat[sidx]  <= sum_n[TIME_BITS] ? TIME_MAX : sum_n[TIME_BITS-1:0];
    end
  end

  a_act_bound: assert property (@(posedge clk) disable iff (rst)
    32'(act) <= SLOTS) else $error("active count overflow");
  a_act_pop: assert property (@(posedge clk) disable iff (rst)
    32'(act) == $countones(vld)) else $error("active count mismatch");
  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    do_fill |-> !vld[fre_s]) else $error("fill of busy slot");

endmodule
`default_nettype wire

### rtl/core/reconnect_backoff_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reconnect_backoff_scheduler_core: exponential backoff reconnect scheduler
// Input channel takes requests (add, remove, connected, dial failed, tick);
// output channel returns one result per request, or for a tick one result
// per dialed or dropped slot and a closing done result with last set.
// A single request is decided once the output register is free, and its
// result is loaded into that register. A tick walks the slots one a cycle
// while the output register is free; each dial adds a backoff run that
// doubles the delay until the new attempt count or the cap is reached.
// One request is in work at a time; the next is accepted once the previous
// one has queued its last result. Results sit in one output register; while
// the receiver stalls it holds and the scan waits. Reset clears the table,
// the active count and loads the register defaults; the output register
// comes up empty. Configuration writes go to a plain indexed write port;
// the user must make them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module reconnect_backoff_scheduler_core
  import rbs_pkg::*;
#(
  parameter int SLOTS        = 16,
  parameter int ADDR_BITS    = 48,
  parameter int TIME_BITS    = 40,
  parameter int ATTEMPT_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           req_type,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic [TIME_BITS-1:0] now_time,
  input  wire logic [15:0]          live_mask,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                kind,
  output logic [ADDR_BITS-1:0]      peer_address,
  output logic [3:0]                slot,
  output logic                      last
);

  rbs_cmd_t cmd;
  rbs_sts_t sts;
  logic     rdy, in_fire, out_take, out_free;

  assign in_stall = !rdy;
  assign in_fire  = in_valid && rdy;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  rbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .in_ready(rdy)
  );

  rbs_dp #(
    .SLOTS(SLOTS), .ADDR_BITS(ADDR_BITS), .TIME_BITS(TIME_BITS),
    .ATTEMPT_BITS(ATTEMPT_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .req_type(req_type), .address(address), .now_time(now_time),
    .live_mask(live_mask), .cmd(cmd), .sts(sts), .out_take(out_take),
    .out_valid(out_valid), .out_kind(kind), .out_addr(peer_address),
    .out_slot(slot), .out_last(last)
  );

endmodule
`default_nettype wire

### dv/rbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_checker: result predictor and scoreboard for the backoff scheduler
// Watches the request, result and register-write ports, keeps a shadow copy
// of the target table, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module rbs_checker
  import rbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [47:0] address,
  input  wire logic [39:0] now_time,
  input  wire logic [15:0] live_mask,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [47:0] peer_address,
  input  wire logic [3:0]  slot,
  input  wire logic        last,
  output int               fail_count,
  output int               pending,
  output int               dial_count,
  output int               giveup_count
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] addr;
    logic [3:0]  slot;
    logic        last;
  } result_t;

  result_t     sched_q[$];
  logic        tv[16];
  logic [47:0] taddr[16];
  logic [7:0]  tatt[16];
  logic        tfly[16];
  logic [39:0] tdead[16];
  logic [39:0] tnext[16];
  int          tcount;
  logic [19:0] r_base;
  logic [23:0] r_maxbo, r_tmo;
  logic [7:0]  r_maxatt;
  logic [4:0]  r_maxtgt;
  logic        r_persist;

  function automatic logic [39:0] sat_add(logic [39:0] t, logic [63:0] d);
    logic [63:0] s;
    s = {24'd0, t} + d;
    return (s > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

  function automatic logic [63:0] retry_delay(logic [7:0] n);
    logic [63:0] d;
    d = {44'd0, r_base};
    for (int i = 1; i < n && d < {40'd0, r_maxbo}; i++) d = d * 2;
    return (d < {40'd0, r_maxbo}) ? d : {40'd0, r_maxbo};
  endfunction

  function automatic int lookup(logic [47:0] a);
    for (int s = 0; s < 16; s++) if (tv[s] && taddr[s] == a) return s;
    return -1;
  endfunction

  function automatic int vacancy();
    if (tcount >= r_maxtgt) return -1;
    for (int s = 0; s < 16; s++) if (!tv[s]) return s;
    return -1;
  endfunction

  task automatic push(logic [2:0] k, logic [47:0] a, int s, logic l);
    result_t r;
    r.kind = k; r.addr = a; r.slot = s[3:0]; r.last = l;
    sched_q.insert(sched_q.size(), r);
  endtask

  task automatic refresh(int s, logic [39:0] now);
    tatt[s] = '0; tfly[s] = 1'b0; tnext[s] = now;
  endtask

  task automatic occupy(int s, logic [47:0] a, logic [39:0] now);
    tv[s] = 1'b1; taddr[s] = a; tdead[s] = '0; refresh(s, now); tcount++;
  endtask

  task automatic predict(logic [2:0] rq, logic [47:0] a, logic [39:0] now,
                         logic [15:0] live);
    int s;
    case (rq)
      REQ_ADD: begin
        s = lookup(a);
        if (s >= 0) push(KIND_PRESENT, a, s, 1'b1);
        else begin
          s = vacancy();
          if (s < 0) push(KIND_FULL, a, 0, 1'b1);
          else begin
            occupy(s, a, now); push(KIND_ADDED, a, s, 1'b1);
          end
        end
      end
      REQ_REMOVE: begin
        s = lookup(a);
        if (s < 0) push(KIND_NOTFND, a, 0, 1'b1);
        else begin
          tv[s] = 1'b0; if (tcount > 0) tcount--; push(KIND_REMOVED, a, s, 1'b1);
        end
      end
      REQ_CONN: begin
        s = lookup(a);
        if (s >= 0) begin
          refresh(s, now); push(KIND_DONE, a, s, 1'b1);
        end else if (!r_persist) push(KIND_NOTFND, a, 0, 1'b1);
        else begin
          s = vacancy();
          if (s < 0) push(KIND_FULL, a, 0, 1'b1);
          else begin
            occupy(s, a, now); push(KIND_ADDED, a, s, 1'b1);
          end
        end
      end
      REQ_FAIL: begin
        s = lookup(a);
        if (s < 0) push(KIND_NOTFND, a, 0, 1'b1);
        else begin
          tfly[s] = 1'b0; push(KIND_DONE, a, s, 1'b1);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < 16; i++) begin
          if (!tv[i]) continue;
          if (live[i]) begin refresh(i, now); continue; end
          if (tfly[i] && now < tdead[i]) continue;
          if (tnext[i] > now) continue;
          if (r_maxatt > 0 && tatt[i] >= r_maxatt) begin
            push(KIND_GIVEUP, taddr[i], i, 1'b0);
            tv[i] = 1'b0; if (tcount > 0) tcount--;
            continue;
          end
          if (tatt[i] != 8'hFF) tatt[i]++;
          tfly[i] = 1'b1;
          tdead[i] = sat_add(now, {40'd0, r_tmo});
          tnext[i] = sat_add(now, retry_delay(tatt[i]));
          push(KIND_DIAL, taddr[i], i, 1'b0);
        end
        push(KIND_DONE, 48'd0, 0, 1'b1);
      end
      default: push(KIND_DONE, a, 0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (tv[i]) tv[i] = 1'b0;
      sched_q.delete();
      tcount = 0;
      r_base = 20'd1000; r_maxbo = 24'd60000; r_tmo = 24'd10000;
      r_maxatt = 8'd0; r_maxtgt = 5'd16; r_persist = 1'b0;
      fail_count <= 0; dial_count <= 0; giveup_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE:    r_base = cfg_data[19:0];
          REG_MAXBO:   r_maxbo = cfg_data;
          REG_TIMEOUT: r_tmo = cfg_data;
          REG_MAXATT:  r_maxatt = cfg_data[7:0];
          REG_MAXTGT:  r_maxtgt = cfg_data[4:0];
          REG_PERSIST: r_persist = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d addr=%h slot=%0d last=%0d",
                   $time, kind, peer_address, slot, last);
          fail_count <= fail_count + 1;
        end else begin
          want = sched_q.pop_front();
          if (want != {kind, peer_address, slot, last}) begin
            $display("%0t: mismatch expected kind=%0d addr=%h slot=%0d last=%0d",
                     $time, want.kind, want.addr, want.slot, want.last);
            $display("%0t:          actual   kind=%0d addr=%h slot=%0d last=%0d",
                     $time, kind, peer_address, slot, last);
            fail_count <= fail_count + 1;
          end
          if (kind == KIND_DIAL) dial_count <= dial_count + 1;
          if (kind == KIND_GIVEUP) giveup_count <= giveup_count + 1;
        end
      end
      if (in_valid && !in_stall) predict(req_type, address, now_time, live_mask);
    end
    pending <= sched_q.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the reconnect backoff scheduler
// Drives directed then random requests through several register settings
// and idling phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import rbs_pkg::*;

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid, in_stall;
  logic [2:0]  req_type;
  logic [47:0] address;
  logic [39:0] now_time;
  logic [15:0] live_mask;
  logic        out_valid, out_stall;
  logic [2:0]  kind;
  logic [47:0] peer_address;
  logic [3:0]  slot;
  logic        last;
  int          fail_count, pending, dial_count, giveup_count;
  int          send_idle, recv_idle, hold_off, cycles, sent;
  logic [39:0] clock_ms;
  logic [47:0] pool[8];

  reconnect_backoff_scheduler_core DUT (.*);

  rbs_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // hold valid across back-to-back transactions; drop it only when idling
  task automatic send(logic [2:0] rq, logic [47:0] a, logic [39:0] t, logic [15:0] lm);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1; req_type <= rq; address <= a; now_time <= t; live_mask <= lm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_burst(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(4000);
      if (pick < 35)
        send(REQ_TICK, {$urandom, $urandom}, clock_ms,
             ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0);
      else if (pick < 60) send(REQ_ADD, pool[$urandom_range(7)], clock_ms, 16'($urandom));
      else if (pick < 70) send(REQ_REMOVE, pool[$urandom_range(7)], clock_ms, 0);
      else if (pick < 80) send(REQ_CONN, pool[$urandom_range(7)], clock_ms, 0);
      else if (pick < 92) send(REQ_FAIL, pool[$urandom_range(7)], clock_ms, 0);
      else if (pick < 96) send(3'($urandom_range(7)), {$urandom, $urandom},
                               {$urandom, $urandom}, 16'($urandom));
      else send(REQ_ADD, {$urandom, $urandom}, clock_ms, 0);
    end
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = 0; cfg_data = 0;
    in_valid = 1'b0; req_type = 0; address = 0; now_time = 0; live_mask = 0;
    send_idle = 0; recv_idle = 0; hold_off = 0; sent = 0; clock_ms = 0;
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    pool[0] = 48'h0; pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: extremes, every request, full table, give up, saturation
    write_reg(REG_MAXATT, 2);
    write_reg(REG_PERSIST, 1);
    write_reg(REG_MAXTGT, 2);
    send(REQ_ADD, pool[0], 0, 0);
    send(REQ_ADD, pool[0], 0, 0);
    send(REQ_ADD, pool[1], 0, 0);
    send(REQ_ADD, pool[2], 0, 0);
    send(REQ_CONN, pool[3], 0, 0);
    send(REQ_TICK, 0, 0, 16'h0);
    send(REQ_TICK, 0, 5, 16'h0);
    send(REQ_FAIL, pool[0], 6, 0);
    send(REQ_FAIL, pool[5], 6, 0);
    send(REQ_TICK, 0, 40'd5000, 16'h0002);
    send(REQ_TICK, 0, 40'd9000, 16'h0);
    send(REQ_TICK, 0, 40'd99000, 16'hFFFF);
    send(REQ_REMOVE, pool[1], 0, 0);
    send(REQ_REMOVE, pool[1], 0, 0);
    send(REQ_CONN, pool[4], 40'hFF_FFFF_FFFF, 0);
    send(REQ_TICK, 0, 40'hFF_FFFF_FFFF, 0);
    send(3'd5, 48'hFFFF_FFFF_FFFF, 0, 16'hFFFF);
    send(3'd7, 48'h0, 40'hFF_FFFF_FFFF, 0);
    settle();
    write_reg(REG_PERSIST, 0);
    send(REQ_CONN, pool[6], 0, 0);
    settle();

    // random phases through several settings and idling mixes
    write_reg(REG_MAXTGT, 16); write_reg(REG_MAXATT, 0);
    write_reg(REG_BASE, 1); write_reg(REG_MAXBO, 24'hFF_FFFF);
    write_reg(REG_TIMEOUT, 1);
    random_burst(70);
    settle();
    write_reg(REG_BASE, 20'hF_FFFF); write_reg(REG_MAXBO, 1);
    write_reg(REG_TIMEOUT, 24'hFF_FFFF); write_reg(REG_MAXATT, 255);
    write_reg(REG_PERSIST, 1); write_reg(REG_MAXTGT, 0);
    send_idle = 82;
    random_burst(40);
    settle();
    write_reg(REG_MAXTGT, 9); write_reg(REG_BASE, 700);
    write_reg(REG_MAXBO, 9000); write_reg(REG_TIMEOUT, 2500);
    write_reg(REG_MAXATT, 3);
    send_idle = 0; recv_idle = 82;
    random_burst(80);
    settle();
    send_idle = 34; recv_idle = 34;
    write_reg(REG_MAXATT, 1); write_reg(REG_PERSIST, 0);
    hold_off = 300;
    random_burst(70);
    settle();

    $display("Ran %0d requests over six register settings and four idling mixes;",
             sent);
    $display("saw %0d dials and %0d give-ups.", dial_count, giveup_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
